FILE: hw/rtl/lpi_pkg.sv
// Package with shared constants, types and helpers for the line-plane intersection unit.
`default_nettype none
package lpi_pkg;
  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int ThrW     = 31;
  localparam int AddrW    = 5;
  localparam int QuoW     = DataW + FracBits + 2;

  localparam logic [AddrW-1:0] RegPlaneA  = AddrW'(0);
  localparam logic [AddrW-1:0] RegPlaneB  = AddrW'(4);
  localparam logic [AddrW-1:0] RegPlaneC  = AddrW'(8);
  localparam logic [AddrW-1:0] RegOffset  = AddrW'(12);
  localparam logic [AddrW-1:0] RegThresh  = AddrW'(16);

  typedef logic signed [DataW-1:0] fix_t;

  typedef struct packed {
    fix_t start_x;
    fix_t start_y;
    fix_t start_z;
    fix_t dir_x;
    fix_t dir_y;
    fix_t dir_z;
  } line_t;

  // Divider sideband: hit flag, quotient sign and the line itself.
  localparam int SideW = 2 + $bits(line_t);

  typedef struct packed {
    logic hit;
    fix_t param_t;
    fix_t point_x;
    fix_t point_y;
    fix_t point_z;
  } isect_t;

  typedef struct packed {
    fix_t plane_a;
    fix_t plane_b;
    fix_t plane_c;
    fix_t plane_offset;
    logic [ThrW-1:0] parallel_threshold;
  } plane_cfg_t;

  // Saturate a wide signed value to the 32-bit signed range.
  function automatic fix_t sat(input logic signed [QuoW+FracBits:0] v);
    logic signed [QuoW+FracBits:0] hi;
    logic signed [QuoW+FracBits:0] lo;
    hi = (QuoW+FracBits+1)'(signed'(33'sh0_7FFF_FFFF));
    lo = -hi - 1;
    if (v > hi) return fix_t'(hi);
    else if (v < lo) return fix_t'(lo);
    else return fix_t'(v);
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/lpi_if.sv
// Valid/ready channel interfaces for lines in and intersections out.
`default_nettype none
interface lpi_line_if;
  logic valid;
  logic ready;
  lpi_pkg::line_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpi_isect_if;
  logic valid;
  logic ready;
  lpi_pkg::isect_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lpi_regs.sv
// APB register file holding the plane coefficients and the parallel threshold.
`default_nettype none
module lpi_regs (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [lpi_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output lpi_pkg::plane_cfg_t cfg
);
  import lpi_pkg::*;
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plane_a <= '0;
      cfg.plane_b <= '0;
      cfg.plane_c <= fix_t'(32'sd65536);
      cfg.plane_offset <= '0;
      cfg.parallel_threshold <= ThrW'(1);
    end else if (wr) begin
      unique case (paddr)
        RegPlaneA: cfg.plane_a <= pwdata;
        RegPlaneB: cfg.plane_b <= pwdata;
        RegPlaneC: cfg.plane_c <= pwdata;
        RegOffset: cfg.plane_offset <= pwdata;
        RegThresh: cfg.parallel_threshold <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (paddr)
      RegPlaneA: prdata = cfg.plane_a;
      RegPlaneB: prdata = cfg.plane_b;
      RegPlaneC: prdata = cfg.plane_c;
      RegOffset: prdata = cfg.plane_offset;
      RegThresh: prdata = {1'b0, cfg.parallel_threshold};
      default:   prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/lpi_div.sv
// Pipelined restoring divider, one quotient bit per stage, carrying a sideband.
`default_nettype none
module lpi_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic [lpi_pkg::QuoW-1:0] num,
  input  wire logic [lpi_pkg::DataW-1:0] den,
  input  wire logic [lpi_pkg::SideW-1:0] side_in,
  output logic out_valid,
  output logic [lpi_pkg::QuoW-1:0] quo,
  output logic [lpi_pkg::SideW-1:0] side_out
);
  import lpi_pkg::*;
  logic [QuoW:0] vld;
  logic [QuoW-1:0] q [QuoW+1];
  logic [DataW-1:0] rem [QuoW+1];
  logic [DataW-1:0] dv [QuoW+1];
  logic [SideW-1:0] sd [QuoW+1];

  assign vld[0] = in_valid;
  assign q[0] = num;
  assign rem[0] = '0;
  assign dv[0] = den;
  assign sd[0] = side_in;

  // Each stage shifts in one dividend bit and makes one quotient bit.
  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic [DataW:0] trial;
    logic [DataW:0] diff;
    assign trial = {rem[s], q[s][QuoW-1]};
    assign diff = trial - {1'b0, dv[s]};
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else if (en) vld[s+1] <= vld[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[s+1] <= dv[s];
        sd[s+1] <= sd[s];
        if (!diff[DataW]) begin
          rem[s+1] <= diff[DataW-1:0];
          q[s+1] <= {q[s][QuoW-2:0], 1'b1};
        end else begin
          rem[s+1] <= trial[DataW-1:0];
          q[s+1] <= {q[s][QuoW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[QuoW];
  assign quo = q[QuoW];
  assign side_out = sd[QuoW];
endmodule
`default_nettype wire

FILE: hw/rtl/lpi_dot.sv
// Dot-product stages: plane products, free and slope terms, parallel test.
`default_nettype none
module lpi_dot (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire lpi_pkg::line_t line,
  input  wire lpi_pkg::plane_cfg_t cfg,
  output logic out_valid,
  output lpi_pkg::line_t line_out,
  output lpi_pkg::fix_t free_term,
  output lpi_pkg::fix_t slope,
  output logic parallel
);
  import lpi_pkg::*;
  localparam int PW = 2*DataW - FracBits;
  localparam int SW = QuoW + FracBits + 1;

  logic v1, v2;
  line_t l1, l2;
  logic signed [PW-1:0] pf [3];
  logic signed [PW-1:0] ps [3];
  fix_t off1;
  logic [ThrW-1:0] thr1, thr2;
  logic signed [SW-1:0] fsum, ssum;
  logic [DataW:0] mag;

  // Stage 1: six multiplies, floor scaling by dropping fraction bits.
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l1 <= line;
      off1 <= cfg.plane_offset;
      thr1 <= cfg.parallel_threshold;
      pf[0] <= PW'((64'(cfg.plane_a) * 64'(line.start_x)) >>> FracBits);
      pf[1] <= PW'((64'(cfg.plane_b) * 64'(line.start_y)) >>> FracBits);
      pf[2] <= PW'((64'(cfg.plane_c) * 64'(line.start_z)) >>> FracBits);
      ps[0] <= PW'((64'(cfg.plane_a) * 64'(line.dir_x)) >>> FracBits);
      ps[1] <= PW'((64'(cfg.plane_b) * 64'(line.dir_y)) >>> FracBits);
      ps[2] <= PW'((64'(cfg.plane_c) * 64'(line.dir_z)) >>> FracBits);
    end
  end

  assign fsum = SW'(pf[0]) + SW'(pf[1]) + SW'(pf[2]) + SW'(off1);
  assign ssum = SW'(ps[0]) + SW'(ps[1]) + SW'(ps[2]);

  // Stage 2: sums and saturation.
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l2 <= l1;
      thr2 <= thr1;
      free_term <= sat(fsum);
      slope <= sat(ssum);
    end
  end

  assign mag = slope[DataW-1] ? (DataW+1)'(-33'(slope)) : (DataW+1)'(slope);
  assign parallel = mag <= (DataW+1)'(thr2);
  assign out_valid = v2;
  assign line_out = l2;
endmodule
`default_nettype wire

FILE: hw/rtl/lpi_point.sv
// Point stages: sign fix and saturation of t, then start + dir * t.
`default_nettype none
module lpi_point (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic neg,
  input  wire logic hit,
  input  wire logic [lpi_pkg::QuoW-1:0] quo,
  input  wire lpi_pkg::line_t line,
  output logic out_valid,
  output lpi_pkg::isect_t res
);
  import lpi_pkg::*;
  localparam int SW = QuoW + FracBits + 1;
  localparam int PW = 2*DataW - FracBits;

  logic v1, v2;
  logic h1, h2;
  fix_t t1, t2;
  line_t l1, l2;
  logic signed [SW-1:0] sq;
  logic signed [PW-1:0] m [3];

  assign sq = neg ? -SW'(quo) : SW'(quo);

  // Stage 1: signed, saturated t.
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h1 <= hit;
      l1 <= line;
      t1 <= hit ? sat(sq) : '0;
    end
  end

  // Stage 2: direction products.
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h2 <= h1;
      t2 <= t1;
      l2 <= l1;
      m[0] <= PW'((64'(l1.dir_x) * 64'(t1)) >>> FracBits);
      m[1] <= PW'((64'(l1.dir_y) * 64'(t1)) >>> FracBits);
      m[2] <= PW'((64'(l1.dir_z) * 64'(t1)) >>> FracBits);
    end
  end

  // Stage 3: add start and saturate; zero everything on a miss.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res.hit <= h2;
      res.param_t <= t2;
      res.point_x <= h2 ? sat(SW'(l2.start_x) + SW'(m[0])) : '0;
      res.point_y <= h2 ? sat(SW'(l2.start_y) + SW'(m[1])) : '0;
      res.point_z <= h2 ? sat(SW'(l2.start_z) + SW'(m[2])) : '0;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/line_plane_intersection_unit.sv
// Top level of the line-plane intersection unit.
//
//  channel   dir   handshake     payload
//  lin       in    valid/ready   start_x..z, dir_x..z (Q16.16)
//  isect     out   valid/ready   hit, param_t, point_x..z
//  apb       in    psel/penable  plane_a/b/c, plane_offset, parallel_threshold
//
// One line enters per cycle while the output is not stalled; the pipeline is the dot
// stages, the 50 divider stages and the point stages. The 50-stage divider sets the depth.
// rst is synchronous and clears all valid bits. When the output stalls the
// whole pipeline freezes; a skid register keeps ready registered and passes
// the result straight through while the output is not stalled.
`default_nettype none
module line_plane_intersection_unit (
  input  wire logic clk,
  input  wire logic rst,
  lpi_line_if.sink lin,
  lpi_isect_if.source isect,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [lpi_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import lpi_pkg::*;

  plane_cfg_t cfg;
  logic en;
  logic dv;
  line_t dl;
  fix_t free_term, slope;
  logic parallel;
  logic [QuoW-1:0] num, quo;
  logic [DataW-1:0] den;
  logic [SideW-1:0] side_in, side_out;
  logic qv, pv;
  isect_t pres;
  logic skid_v;
  isect_t skid_d;
  logic [DataW:0] fmag;
  logic fneg, sneg;

  lpi_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Pipeline advances unless the skid register holds an untaken result.
  assign en = !skid_v;
  assign lin.ready = en;

  lpi_dot u_dot (
    .clk, .rst, .en, .in_valid(lin.valid), .line(lin.data), .cfg,
    .out_valid(dv), .line_out(dl), .free_term, .slope, .parallel
  );

  // Divider operands: |free| << FracBits over |slope|, or zero over one when parallel.
  assign fneg = free_term[DataW-1];
  assign sneg = slope[DataW-1];
  assign fmag = fneg ? (DataW+1)'(-33'(free_term)) : (DataW+1)'(free_term);
  assign num = parallel ? '0 : QuoW'({fmag, {FracBits{1'b0}}});
  assign den = parallel ? DataW'(1) :
               (sneg ? DataW'(-33'(slope)) : DataW'(slope));
  assign side_in = {!parallel, (fneg == sneg) && (free_term != '0), dl};

  lpi_div u_div (
    .clk, .rst, .en, .in_valid(dv), .num, .den, .side_in,
    .out_valid(qv), .quo, .side_out
  );

  lpi_point u_point (
    .clk, .rst, .en, .in_valid(qv),
    .neg(side_out[SideW-2]), .hit(side_out[SideW-1]), .quo,
    .line(line_t'(side_out[SideW-3:0])),
    .out_valid(pv), .res(pres)
  );

  // Skid register catches the result leaving the pipeline during a stall.
  always_ff @(posedge clk) begin
    if (rst) skid_v <= 1'b0;
    else if (skid_v) skid_v <= !isect.ready;
    else skid_v <= pv && !isect.ready;
  end
  always_ff @(posedge clk) begin
    if (!skid_v) skid_d <= pres;
  end

  assign isect.valid = skid_v || pv;
  assign isect.data = skid_v ? skid_d : pres;
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the line-plane intersection unit.
`default_nettype none
module tb_top;
  import lpi_pkg::*;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lpi_line_if lin ();
  lpi_isect_if isect ();

  line_plane_intersection_unit i_dut (
    .clk(clk), .rst(rst), .lin(lin.sink), .isect(isect.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int PipeDepth = 60;
  localparam longint CycleLimit = 400000;

  // Local copy of the plane registers.
  logic signed [63:0] coef_a, coef_b, coef_c, coef_off, thresh;

  isect_t hits_pending[$];
  int errors;
  longint cycles;
  bit hold_off;

  // Free-running clock, period 4.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Fixed-point product, floored back to the Q format.
  function automatic logic signed [63:0] qmul(input logic signed [63:0] x,
                                              input logic signed [63:0] y);
    logic signed [63:0] p;
    p = x * y;
    return p >>> FracBits;
  endfunction

  function automatic isect_t intersect_line(input line_t ln);
    logic signed [63:0] x0, y0, z0, dx, dy, dz, fr, sl, mag, t;
    isect_t r;
    x0 = ln.start_x; y0 = ln.start_y; z0 = ln.start_z;
    dx = ln.dir_x; dy = ln.dir_y; dz = ln.dir_z;
    fr = clamp32(qmul(coef_a, x0) + qmul(coef_b, y0) + qmul(coef_c, z0) + coef_off);
    sl = clamp32(qmul(coef_a, dx) + qmul(coef_b, dy) + qmul(coef_c, dz));
    mag = (sl < 0) ? -sl : sl;
    r = '0;
    if (mag > thresh) begin
      t = clamp32((-fr * 64'sd65536) / sl);
      r.hit = 1'b1;
      r.param_t = fix_t'(t);
      r.point_x = fix_t'(clamp32(x0 + qmul(dx, t)));
      r.point_y = fix_t'(clamp32(y0 + qmul(dy, t)));
      r.point_z = fix_t'(clamp32(z0 + qmul(dz, t)));
    end
    return r;
  endfunction

  // Sink side: random stalls, plus a long hold-off on request.
  initial begin
    int gap;
    isect.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        isect.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        isect.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      isect.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    isect_t e;
    if (!rst && isect.valid && isect.ready) begin
      if (hits_pending.size() == 0) begin
        $display("%0t unexpected result %p", $time, isect.data);
        errors++;
      end else begin
        e = hits_pending.pop_front();
        if (isect.data !== e) begin
          $display("%0t mismatch expected %p actual %p", $time, e, isect.data);
          errors++;
        end
      end
    end
  end

  // A line stays offered after its transfer until the next call drops valid or replaces it, or drain drops valid.
  task automatic send_line(input line_t ln, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8));
    if (gap > 0) begin
      lin.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    lin.valid <= 1'b1;
    lin.data <= ln;
    @(posedge clk);
    while (!lin.ready) @(posedge clk);
    hits_pending.push_back(intersect_line(ln));
    @(negedge clk);
  endtask

  // The bus is left in its access phase; the caller idles it.
  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (addr)
      RegPlaneA: coef_a = signed'(val);
      RegPlaneB: coef_b = signed'(val);
      RegPlaneC: coef_c = signed'(val);
      RegOffset: coef_off = signed'(val);
      RegThresh: thresh = {33'b0, val[ThrW-1:0]};
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain;
    lin.valid <= 1'b0;
    while (hits_pending.size() != 0) @(negedge clk);
    repeat (PipeDepth) @(negedge clk);
  endtask

  task automatic set_plane(input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] off,
                           input logic [31:0] th);
    drain();
    write_reg(RegPlaneA, a);
    write_reg(RegPlaneB, b);
    write_reg(RegPlaneC, c);
    write_reg(RegOffset, off);
    write_reg(RegThresh, th);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] rand_fix();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic line_t rand_line();
    line_t ln;
    ln.start_x = rand_fix(); ln.start_y = rand_fix(); ln.start_z = rand_fix();
    ln.dir_x = rand_fix(); ln.dir_y = rand_fix(); ln.dir_z = rand_fix();
    if ($urandom_range(0, 9) == 0) ln.dir_z = '0;
    return ln;
  endfunction

  // Corner lines at the reset plane z = 0, then at three other plane settings.
  task automatic test_directed;
    line_t ln;
    ln = '{32'sh0001_0000, 32'sh0002_0000, 32'sh0005_0000, 0, 0, -32'sh0001_0000};
    send_line(ln, 0);
    ln = '{0, 0, 32'sh0005_0000, 32'sh0001_0000, 0, 0};
    send_line(ln, 0);
    ln = '{0, 0, 0, 0, 0, 0};
    send_line(ln, 0);
    ln = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
           32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001};
    send_line(ln, 0);
    ln = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
           32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
    send_line(ln, 0);
    ln = '{0, 0, 32'sh7FFF_FFFF, 0, 0, 32'sh0000_0002};
    send_line(ln, 0);
    ln = '{-1, -1, -1, -1, -1, -1};
    send_line(ln, 0);
    set_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    ln = '{-1, 1, -1, 1, -1, 1};
    send_line(ln, 0);
    send_line(rand_line(), 0);
    set_plane(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_line(rand_line(), 0);
    set_plane(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'h0);
    ln = '{0, 0, 0, 32'sh0001_0000, -32'sh0001_0000, 0};
    send_line(ln, 0);
    ln = '{0, 0, 0, 32'sh0001_0000, 0, 0};
    send_line(ln, 0);
  endtask

  // Random lines under several plane settings.
  task automatic test_random;
    for (int p = 0; p < 7; p++) begin
      if (p == 0) set_plane(0, 0, 32'h0001_0000, 0, 1);
      else set_plane(rand_fix(), rand_fix(), rand_fix(), rand_fix(),
                     $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 16));
      for (int i = 0; i < 190; i++) send_line(rand_line(), 0);
    end
  endtask

  // Back-to-back lines while the sink holds off, so the pipeline fills.
  task automatic test_backpressure;
    set_plane(32'h0000_8000, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 16);
    hold_off = 1'b1;
    for (int i = 0; i < 120; i++) send_line(rand_line(), 1);
    for (int i = 0; i < 30; i++) send_line(rand_line(), i % 2);
  endtask

  initial begin
    clk = 1'b0;
    errors = 0; cycles = 0; hold_off = 1'b0;
    coef_a = 0; coef_b = 0; coef_c = 65536; coef_off = 0; thresh = 1;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    lin.valid = 1'b0; lin.data = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/lpi_pkg.sv
hw/rtl/lpi_if.sv
hw/rtl/lpi_regs.sv
hw/rtl/lpi_div.sv
hw/rtl/lpi_dot.sv
hw/rtl/lpi_point.sv
hw/rtl/line_plane_intersection_unit.sv
tb/sv/tb_top.sv
